@@ rtl/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg
// Types, constants and calendar tables shared by the date add/diff pipeline.
// ----------------------------------------------------------------------------
package gdad_pkg;

	localparam logic [13:0] MAX_YEAR    = 14'd9999;
	localparam logic [21:0] LAST_DAYNUM = 22'd3652058;
	// ceil(2^32 * 400 / 146097): years elapsed from a day number
	localparam logic [23:0] YEAR_RECIP  = 24'd11759222;
	// 5243 / 2^19 ~ 1/100, exact for values below 16384
	localparam logic [12:0] HUND_RECIP  = 13'd5243;
	localparam int unsigned HUND_SHIFT  = 19;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	typedef struct packed {
		logic        inv;
		logic        oor;
		logic [22:0] diff;
		logic        later;
		logic        eq;
	} side_t;

	// Days in the year before the first of month m
	function automatic logic [8:0] days_before(input logic [3:0] m, input logic lp);
		logic [8:0] d;
		begin
			case (m)
				4'd1:    d = 9'd0;
				4'd2:    d = 9'd31;
				4'd3:    d = 9'd59;
				4'd4:    d = 9'd90;
				4'd5:    d = 9'd120;
				4'd6:    d = 9'd151;
				4'd7:    d = 9'd181;
				4'd8:    d = 9'd212;
				4'd9:    d = 9'd243;
				4'd10:   d = 9'd273;
				4'd11:   d = 9'd304;
				4'd12:   d = 9'd334;
				default: d = 9'd0;
			endcase
			if (lp && m > 4'd2 && m <= 4'd12) begin
				d = d + 9'd1;
			end
			return d;
		end
	endfunction

	// Length of month m; zero for a month code that means nothing
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] l;
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
				4'd2:                                       l = lp ? 5'd29 : 5'd28;
				default:                                    l = 5'd0;
			endcase
			return l;
		end
	endfunction

endpackage

@@ rtl/gdad_daynum.sv @@
// ----------------------------------------------------------------------------
// gdad_daynum
// Three-stage conversion of a calendar date to a day number from 0001-01-01,
// with a date check.
// ----------------------------------------------------------------------------
module gdad_daynum (
	input  logic        clk,
	input  logic        en,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	output logic [21:0] daynum,
	output logic        ok
);
	import gdad_pkg::*;

	logic [13:0] y_s1;
	logic [3:0]  m_s1;
	logic [4:0]  d_s1;
	logic [26:0] yq_s1;

	logic [7:0]  h;
	logic [14:0] hund;
	logic        cent;
	logic        leap;
	logic [13:0] p;
	logic [4:0]  mlen;

	logic [22:0] p365_s2;
	logic [11:0] p4_s2;
	logic [7:0]  ph_s2;
	logic [8:0]  cd_s2;
	logic        ok_s2;

	logic [22:0] n;
	logic [21:0] n_s3;
	logic        ok_s3;

	// Stage 1: hold the date, scale the year toward year/100
	always_ff @(posedge clk) begin
		if (en) begin
			y_s1  <= year;
			m_s1  <= month;
			d_s1  <= day;
			yq_s1 <= 27'(year) * 27'(HUND_RECIP);
		end
	end

	// Leap rule and date check from year/100
	assign h    = yq_s1[HUND_SHIFT +: 8];
	assign hund = {1'b0, h, 6'b0} + {2'b0, h, 5'b0} + {5'b0, h, 2'b0};
	assign cent = ({1'b0, y_s1} == hund);
	assign leap = ((y_s1[1:0] == 2'b00) && !cent) || (cent && (h[1:0] == 2'b00));
	assign p    = y_s1 - 14'd1;
	assign mlen = month_len(m_s1, leap);

	// Stage 2: whole years in days, day of year
	always_ff @(posedge clk) begin
		if (en) begin
			p365_s2 <= 23'(p) * 23'd365;
			p4_s2   <= p[13:2];
			ph_s2   <= h - 8'(cent);
			cd_s2   <= days_before(m_s1, leap) + 9'(d_s1) - 9'd1;
			ok_s2   <= (y_s1 >= 14'd1) && (y_s1 <= MAX_YEAR) && (d_s1 >= 5'd1)
				&& (d_s1 <= mlen);
		end
	end

	// Stage 3: add the leap corrections
	assign n = p365_s2 + 23'(p4_s2) + 23'(ph_s2[7:2]) - 23'(ph_s2) + 23'(cd_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3  <= n[21:0];
			ok_s3 <= ok_s2;
		end
	end

	assign daynum = n_s3;
	assign ok     = ok_s3;

endmodule

@@ rtl/gdad_civil.sv @@
// ----------------------------------------------------------------------------
// gdad_civil
// Four-stage conversion of a day number back to year, month and day.
// ----------------------------------------------------------------------------
module gdad_civil (
	input  logic                 clk,
	input  logic                 en,
	input  logic [21:0]          daynum,
	output gdad_pkg::date_t      date
);
	import gdad_pkg::*;

	logic [21:0] sp2;
	logic [45:0] prod;

	logic [13:0] e_s5;
	logic [21:0] s_s5;

	logic [22:0] e365_s6;
	logic [26:0] eh_s6;
	logic [13:0] e_s6;
	logic [21:0] s_s6;

	logic [7:0]  h;
	logic [14:0] hund;
	logic [6:0]  m100;
	logic [6:0]  m1;
	logic [7:0]  h1;
	logic [13:0] e1;
	logic        wrap;
	logic        leap0;
	logic        leap1;
	logic [22:0] start;

	logic [22:0] start_s7;
	logic        leap0_s7;
	logic        leap1_s7;
	logic [13:0] e_s7;
	logic [21:0] s_s7;

	logic        back;
	logic [22:0] r;

	logic [13:0] year_s8;
	logic [8:0]  r_s8;
	logic        lp_s8;

	logic [3:0]  mon;
	logic [8:0]  dd;

	// Stage 5: estimate years elapsed, never low and at most one high
	assign sp2  = daynum + 22'd2;
	assign prod = 46'(sp2) * 46'(YEAR_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s5 <= prod[45:32];
			s_s5 <= daynum;
		end
	end

	// Stage 6: scale the estimate
	always_ff @(posedge clk) begin
		if (en) begin
			e365_s6 <= 23'(e_s5) * 23'd365;
			eh_s6   <= 27'(e_s5) * 27'(HUND_RECIP);
			e_s6    <= e_s5;
			s_s6    <= s_s5;
		end
	end

	// Start of year e+1 for the estimate e, leap flags for years e and e+1
	assign h     = eh_s6[HUND_SHIFT +: 8];
	assign hund  = {1'b0, h, 6'b0} + {2'b0, h, 5'b0} + {5'b0, h, 2'b0};
	assign m100  = 7'({1'b0, e_s6} - hund);
	assign start = e365_s6 + 23'(e_s6[13:2]) - 23'(h) + 23'(h[7:2]);
	assign leap0 = ((e_s6[1:0] == 2'b00) && (m100 != 7'd0))
		|| ((m100 == 7'd0) && (h[1:0] == 2'b00));
	assign e1    = e_s6 + 14'd1;
	assign wrap  = (m100 == 7'd99);
	assign m1    = wrap ? 7'd0 : m100 + 7'd1;
	assign h1    = wrap ? h + 8'd1 : h;
	assign leap1 = ((e1[1:0] == 2'b00) && (m1 != 7'd0))
		|| ((m1 == 7'd0) && (h1[1:0] == 2'b00));

	// Stage 7: hold year start and leap flags
	always_ff @(posedge clk) begin
		if (en) begin
			start_s7 <= start;
			leap0_s7 <= leap0;
			leap1_s7 <= leap1;
			e_s7     <= e_s6;
			s_s7     <= s_s6;
		end
	end

	// Step back one year when the estimate overshoots
	assign back = ({1'b0, s_s7} < start_s7);
	assign r    = back ? {1'b0, s_s7} - start_s7 + 23'd365 + 23'(leap0_s7)
		: {1'b0, s_s7} - start_s7;

	// Stage 8: year and day of year
	always_ff @(posedge clk) begin
		if (en) begin
			year_s8 <= back ? e_s7 : e_s7 + 14'd1;
			r_s8    <= r[8:0];
			lp_s8   <= back ? leap0_s7 : leap1_s7;
		end
	end

	// Month by parallel compares against month starts
	always_comb begin
		mon = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (r_s8 >= days_before(4'(k), lp_s8)) begin
				mon = 4'(k);
			end
		end
	end

	assign dd         = r_s8 - days_before(mon, lp_s8) + 9'd1;
	assign date.year  = year_s8;
	assign date.month = mon;
	assign date.day   = dd[4:0];

endmodule

@@ rtl/gregorian_date_add_and_diff_top.sv @@
// Throughput: one request per cycle while the output is not stalled; each stage is a register of the pipeline.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n, asynchronous, active low) clears the valid bits only.
// ----------------------------------------------------------------------------
// gregorian_date_add_and_diff_top
// Shifts a Gregorian date by a signed day count and measures the signed
// distance in days to a second date.
// ----------------------------------------------------------------------------
module gregorian_date_add_and_diff_top #(
	parameter int OFFSET_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [13:0]                   year_in,
	input  logic [3:0]                    month_in,
	input  logic [4:0]                    day_in,
	input  logic signed [OFFSET_BITS-1:0] offset_days,
	input  logic [13:0]                   other_year,
	input  logic [3:0]                    other_month,
	input  logic [4:0]                    other_day,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [13:0]                   sum_year,
	output logic [3:0]                    sum_month,
	output logic [4:0]                    sum_day,
	output logic                          sum_out_of_range,
	output logic signed [22:0]            day_difference,
	output logic                          first_later,
	output logic                          dates_equal,
	output logic                          input_invalid
);
	import gdad_pkg::*;

	localparam int SW = ((OFFSET_BITS > 23) ? OFFSET_BITS : 23) + 1;
	localparam logic signed [SW-1:0] LAST_S = SW'(LAST_DAYNUM);

	logic        adv;
	logic [8:1]  vld_q;
	logic        out_valid_q;

	logic signed [OFFSET_BITS-1:0] off_s1;
	logic signed [OFFSET_BITS-1:0] off_s2;
	logic signed [OFFSET_BITS-1:0] off_s3;

	logic [21:0] n1;
	logic [21:0] n2;
	logic        ok1;
	logic        ok2;

	logic signed [SW-1:0] sum_w;
	logic        oor;
	side_t       side_s4;
	side_t       side_s5;
	side_t       side_s6;
	side_t       side_s7;
	side_t       side_s8;
	logic [21:0] s_s4;

	date_t       date;

	logic [13:0] sum_year_q;
	logic [3:0]  sum_month_q;
	logic [4:0]  sum_day_q;
	logic        oor_q;
	logic [22:0] diff_q;
	logic        later_q;
	logic        eq_q;
	logic        inv_q;

	// Advance everything unless a finished result is held
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[7:1], in_valid};
			out_valid_q <= vld_q[8];
		end
	end

	// Carry the offset alongside the day number conversion
	always_ff @(posedge clk) begin
		if (adv) begin
			off_s1 <= offset_days;
			off_s2 <= off_s1;
			off_s3 <= off_s2;
		end
	end

	gdad_daynum u_first (
		.clk    (clk),
		.en     (adv),
		.year   (year_in),
		.month  (month_in),
		.day    (day_in),
		.daynum (n1),
		.ok     (ok1)
	);

	gdad_daynum u_other (
		.clk    (clk),
		.en     (adv),
		.year   (other_year),
		.month  (other_month),
		.day    (other_day),
		.daynum (n2),
		.ok     (ok2)
	);

	// Shifted day number, range check, difference
	assign sum_w = SW'($signed({1'b0, n1})) + SW'(off_s3);
	assign oor   = (sum_w < 0) || (sum_w > LAST_S);

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s4          <= sum_w[21:0];
			side_s4.inv   <= !(ok1 && ok2);
			side_s4.oor   <= oor;
			side_s4.diff  <= 23'(n1) - 23'(n2);
			side_s4.later <= (n1 > n2);
			side_s4.eq    <= (n1 == n2);
			side_s5       <= side_s4;
			side_s6       <= side_s5;
			side_s7       <= side_s6;
			side_s8       <= side_s7;
		end
	end

	gdad_civil u_civil (
		.clk    (clk),
		.en     (adv),
		.daynum (s_s4),
		.date   (date)
	);

	// Output register: zero the fields that do not apply
	always_ff @(posedge clk) begin
		if (adv) begin
			inv_q <= side_s8.inv;
			if (side_s8.inv) begin
				sum_year_q  <= '0;
				sum_month_q <= '0;
				sum_day_q   <= '0;
				oor_q       <= 1'b0;
				diff_q      <= '0;
				later_q     <= 1'b0;
				eq_q        <= 1'b0;
			end else begin
				oor_q   <= side_s8.oor;
				diff_q  <= side_s8.diff;
				later_q <= side_s8.later;
				eq_q    <= side_s8.eq;
				if (side_s8.oor) begin
					sum_year_q  <= '0;
					sum_month_q <= '0;
					sum_day_q   <= '0;
				end else begin
					sum_year_q  <= date.year;
					sum_month_q <= date.month;
					sum_day_q   <= date.day;
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign sum_year         = sum_year_q;
	assign sum_month        = sum_month_q;
	assign sum_day          = sum_day_q;
	assign sum_out_of_range = oor_q;
	assign day_difference   = diff_q;
	assign first_later      = later_q;
	assign dates_equal      = eq_q;
	assign input_invalid    = inv_q;

	// Invalid input clears the difference fields
	a_inv_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && input_invalid |-> day_difference == 0 && !first_later && !dates_equal)
		else $error("invalid input left difference fields set");

	// Later and equal never both
	a_later_eq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(first_later && dates_equal))
		else $error("first_later and dates_equal both set");

	// Out of range sum carries a zero date
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sum_out_of_range |-> sum_year == 0 && sum_month == 0 && sum_day == 0)
		else $error("out of range sum with nonzero date");

	// A valid sum is a real calendar position
	a_sum_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !input_invalid && !sum_out_of_range |->
		sum_month >= 4'd1 && sum_month <= 4'd12 && sum_day >= 5'd1 && sum_year >= 14'd1)
		else $error("sum date out of calendar");

endmodule

@@ test/gregorian_date_add_and_diff_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_and_diff_top_test
// Drives dated requests with random gaps and random output stalls, predicts
// each shifted date and day difference with a calendar model of its own, and
// checks every result in order against the predicted values.
// ----------------------------------------------------------------------------
module gregorian_date_add_and_diff_top_test;

	localparam int OFFSET_BITS = 20;
	localparam int N_RANDOM    = 1400;
	localparam longint DAYS_400 = 146097;
	localparam longint DAYS_100 = 36524;
	localparam longint DAYS_4   = 1461;
	localparam longint LAST_DAY = 3652058;

	typedef struct packed {
		logic [13:0]                   y1;
		logic [3:0]                    m1;
		logic [4:0]                    d1;
		logic signed [OFFSET_BITS-1:0] off;
		logic [13:0]                   y2;
		logic [3:0]                    m2;
		logic [4:0]                    d2;
	} date_req_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        oor;
		logic [22:0] diff;
		logic        later;
		logic        eq;
		logic        inv;
	} date_res_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [13:0] year_in;
	logic [3:0] month_in;
	logic [4:0] day_in;
	logic signed [OFFSET_BITS-1:0] offset_days;
	logic [13:0] other_year;
	logic [3:0] other_month;
	logic [4:0] other_day;
	logic out_valid;
	logic out_stall;
	logic [13:0] sum_year;
	logic [3:0] sum_month;
	logic [4:0] sum_day;
	logic sum_out_of_range;
	logic signed [22:0] day_difference;
	logic first_later;
	logic dates_equal;
	logic input_invalid;

	date_req_t pending_reqs[$];
	date_res_t expected_results[$];
	int  n_errors;
	int  n_checked;
	int  n_invalid;
	int  n_oor;
	bit  stim_done;
	bit  hold_send;
	int  cycle_cnt;

	gregorian_date_add_and_diff_top #(.OFFSET_BITS(OFFSET_BITS)) dut (.*);

	// Calendar helpers
	function automatic bit leap_year(longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic longint days_in_month(longint y, longint m);
		if (m < 1 || m > 12) begin
			return 0;
		end
		case (m)
			2: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic bit valid_date(longint y, longint m, longint d);
		if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) begin
			return 0;
		end
		return d <= days_in_month(y, m);
	endfunction

	function automatic longint serial_day(longint y, longint m, longint d);
		longint p;
		longint n;
		p = y - 1;
		n = p * 365 + p / 4 - p / 100 + p / 400;
		for (longint k = 1; k < m; k++) begin
			n += days_in_month(y, k);
		end
		return n + d - 1;
	endfunction

	// Predict the result of one request
	function automatic date_res_t predict_shift_and_diff(date_req_t q);
		date_res_t r;
		longint n1, n2, s, dif, q400, rem, q100, q4, q1, y, mo;
		r = '0;
		if (!valid_date(q.y1, q.m1, q.d1) || !valid_date(q.y2, q.m2, q.d2)) begin
			r.inv = 1'b1;
			return r;
		end
		n1 = serial_day(q.y1, q.m1, q.d1);
		n2 = serial_day(q.y2, q.m2, q.d2);
		s = n1 + longint'(q.off);
		if (s < 0 || s > LAST_DAY) begin
			r.oor = 1'b1;
		end else begin
			q400 = s / DAYS_400;
			rem = s % DAYS_400;
			q100 = rem / DAYS_100;
			if (q100 > 3) q100 = 3;
			rem -= q100 * DAYS_100;
			q4 = rem / DAYS_4;
			rem %= DAYS_4;
			q1 = rem / 365;
			if (q1 > 3) q1 = 3;
			rem -= q1 * 365;
			y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
			mo = 1;
			while (mo < 12 && rem >= days_in_month(y, mo)) begin
				rem -= days_in_month(y, mo);
				mo++;
			end
			r.year = y[13:0];
			r.month = mo[3:0];
			r.day = 5'(rem + 1);
		end
		dif = n1 - n2;
		r.diff = dif[22:0];
		r.later = dif > 0;
		r.eq = dif == 0;
		return r;
	endfunction

	function automatic date_req_t make_req(int y1, int m1, int d1, int off,
			int y2, int m2, int d2);
		date_req_t q;
		q.y1 = y1; q.m1 = m1; q.d1 = d1; q.off = off;
		q.y2 = y2; q.m2 = m2; q.d2 = d2;
		return q;
	endfunction

	// Random date, mostly valid
	function automatic void rand_date(output int y, output int m, output int d);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			y = $urandom_range(0, 16383); m = $urandom_range(0, 15); d = $urandom_range(0, 31);
		end else begin
			case ($urandom_range(0, 3))
				0: y = $urandom_range(1, 30);
				1: y = $urandom_range(9970, 9999);
				2: y = 400 * $urandom_range(1, 24) + $urandom_range(0, 1) - 1;
				default: y = $urandom_range(1, 9999);
			endcase
			if (y < 1) y = 1;
			m = $urandom_range(1, 12);
			d = (sel < 20) ? days_in_month(y, m) : $urandom_range(1, days_in_month(y, m));
			if (sel >= 20 && sel < 25) d = days_in_month(y, m) + 1;
		end
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stimulus
	initial begin
		int y1, m1, d1, y2, m2, d2, off;
		arst_n = 1'b0;
		stim_done = 1'b0;
		hold_send = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, leap rules, invalid dates, range overflow
		pending_reqs.push_back(make_req(1, 1, 1, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(9999, 12, 31, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(1, 1, 1, 0, 9999, 12, 31));
		pending_reqs.push_back(make_req(1, 1, 1, -1, 1, 1, 2));
		pending_reqs.push_back(make_req(9999, 12, 31, 1, 9999, 12, 30));
		pending_reqs.push_back(make_req(2000, 2, 28, 1, 2000, 3, 1));
		pending_reqs.push_back(make_req(1900, 2, 28, 1, 1900, 3, 1));
		pending_reqs.push_back(make_req(2004, 2, 29, 365, 2003, 2, 28));
		pending_reqs.push_back(make_req(1900, 2, 29, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(2001, 2, 29, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(2000, 4, 31, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(2000, 1, 0, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(0, 1, 1, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(10000, 1, 1, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(2000, 13, 1, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(2000, 0, 1, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(2000, 1, 1, 0, 2000, 2, 30));
		pending_reqs.push_back(make_req(16383, 15, 31, -1, 16383, 15, 31));
		pending_reqs.push_back(make_req(5000, 6, 15, 524287, 5000, 6, 15));
		pending_reqs.push_back(make_req(5000, 6, 15, -524288, 5000, 6, 16));
		pending_reqs.push_back(make_req(1, 3, 1, -524288, 9999, 1, 1));
		pending_reqs.push_back(make_req(9999, 1, 1, 524287, 1, 12, 31));
		pending_reqs.push_back(make_req(1999, 12, 31, 1, 2000, 1, 1));

		// Let the pipeline drain once before random traffic
		wait (pending_reqs.size() == 0 && expected_results.size() == 0);
		hold_send = 1'b1;
		@(posedge clk);
		hold_send = 1'b0;

		for (int i = 0; i < N_RANDOM; i++) begin
			rand_date(y1, m1, d1);
			rand_date(y2, m2, d2);
			case ($urandom_range(0, 4))
				0: off = $urandom_range(0, 62) - 31;
				1: off = $urandom_range(0, 800) - 400;
				2: off = $urandom_range(0, 1048575) - 524288;
				3: off = ($urandom_range(0, 1)) ? 524287 : -524288;
				default: off = $urandom_range(0, 73000) - 36500;
			endcase
			pending_reqs.push_back(make_req(y1, m1, d1, off, y2, m2, d2));
			// Pause the sender once mid-run until the pipeline drains
			if (i == N_RANDOM / 2) begin
				wait (pending_reqs.size() == 0 && expected_results.size() == 0);
				hold_send = 1'b1;
				repeat (5) @(posedge clk);
				hold_send = 1'b0;
			end
		end
		wait (pending_reqs.size() == 0);
		stim_done = 1'b1;
	end

	// Driver: present the next request, hold it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			{year_in, month_in, day_in, offset_days} <= '0;
			{other_year, other_month, other_day} <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				expected_results.push_back(predict_shift_and_diff(pending_reqs.pop_front()));
			end
			if (pending_reqs.size() > (in_valid ? 0 : 0) && !hold_send
					&& (cycle_cnt % 4000 < 1000 || $urandom_range(0, 99) >= 14)) begin
				in_valid <= 1'b1;
				year_in <= pending_reqs[0].y1;
				month_in <= pending_reqs[0].m1;
				day_in <= pending_reqs[0].d1;
				offset_days <= pending_reqs[0].off;
				other_year <= pending_reqs[0].y2;
				other_month <= pending_reqs[0].m2;
				other_day <= pending_reqs[0].d2;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		date_res_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			cycle_cnt <= 0;
			n_errors = 0;
			n_checked = 0;
			n_invalid = 0;
			n_oor = 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request pending");
					n_errors++;
				end else begin
					e = expected_results.pop_front();
					n_checked++;
					if (e.inv) n_invalid++;
					if (e.oor) n_oor++;
					if (sum_year !== e.year) begin
						$error("sum_year exp %0d got %0d", e.year, sum_year); n_errors++;
					end
					if (sum_month !== e.month) begin
						$error("sum_month exp %0d got %0d", e.month, sum_month); n_errors++;
					end
					if (sum_day !== e.day) begin
						$error("sum_day exp %0d got %0d", e.day, sum_day); n_errors++;
					end
					if (sum_out_of_range !== e.oor) begin
						$error("sum_out_of_range exp %0b got %0b", e.oor, sum_out_of_range);
						n_errors++;
					end
					if (day_difference !== e.diff) begin
						$error("day_difference exp %0d got %0d", $signed(e.diff), day_difference);
						n_errors++;
					end
					if (first_later !== e.later) begin
						$error("first_later exp %0b got %0b", e.later, first_later); n_errors++;
					end
					if (dates_equal !== e.eq) begin
						$error("dates_equal exp %0b got %0b", e.eq, dates_equal); n_errors++;
					end
					if (input_invalid !== e.inv) begin
						$error("input_invalid exp %0b got %0b", e.inv, input_invalid); n_errors++;
					end
				end
			end
			out_stall <= (cycle_cnt % 4000 >= 1000 && cycle_cnt % 4000 < 2000) ? 1'b0
				: ($urandom_range(0, 99) < 14);
		end
	end

	// End of run
	initial begin
		wait (stim_done);
		while (in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
		$display("Checked %0d results: %0d with an invalid date, %0d shifted out of range.",
			n_checked, n_invalid, n_oor);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Timeout
	initial begin
		#200000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
